// ===== design/exti_pkg.sv =====
// Shared types and constants for the external interrupt line controller.
`timescale 1ns / 1ps
`default_nettype none

package exti_pkg;

  localparam int unsigned LINE_W    = 16;
  localparam int unsigned NUM_PORTS = 5;
  localparam int unsigned PSEL_W    = 4;
  localparam int unsigned IRQ_W     = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_MASK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISING_EN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALLING_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_SELECT = 3'd3;

  localparam logic [PSEL_W-1:0] PORT_A = 4'd0;
  localparam logic [PSEL_W-1:0] PORT_B = 4'd1;
  localparam logic [PSEL_W-1:0] PORT_C = 4'd2;
  localparam logic [PSEL_W-1:0] PORT_D = 4'd3;
  localparam logic [PSEL_W-1:0] PORT_E = 4'd4;

  typedef struct packed {
    logic sample;
    logic clear;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== design/exti_lane.sv =====
// One interrupt line: pin select, edge detect and pending bit.
`timescale 1ns / 1ps
`default_nettype none

module exti_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  exti_pkg::lane_ctrl_t                ctrl_i,
  input  logic [exti_pkg::NUM_PORTS-1:0]      pins_i,
  input  logic [exti_pkg::PSEL_W-1:0]         code_i,
  input  logic                                rise_en_i,
  input  logic                                fall_en_i,
  input  logic                                clear_bit_i,
  output logic                                pending_o
);
  import exti_pkg::*;

  logic level;
  logic prev_q, prev_d;
  logic pend_q, pend_d;

  always_comb begin
    case (code_i)
      PORT_A:  level = pins_i[0];
      PORT_B:  level = pins_i[1];
      PORT_C:  level = pins_i[2];
      PORT_D:  level = pins_i[3];
      PORT_E:  level = pins_i[4];
      default: level = 1'b0;
    endcase
  end

  always_comb begin
    prev_d = prev_q;
    pend_d = pend_q;
    if (ctrl_i.sample) begin
      pend_d = pend_q | (level & ~prev_q & rise_en_i) | (~level & prev_q & fall_en_i);
      prev_d = level;
    end
    if (ctrl_i.clear) begin
      pend_d = pend_q & ~clear_bit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      pend_q <= pend_d;
    end
  end

  assign pending_o = pend_d;

endmodule

`default_nettype wire

// ===== design/exti_merge.sv =====
// Request grouping and output register for the line results.
`timescale 1ns / 1ps
`default_nettype none

module exti_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [exti_pkg::LINE_W-1:0]  pending_i,
  input  logic [exti_pkg::LINE_W-1:0]  line_mask_i,
  input  logic                         out_ready_i,
  output logic                         ready_o,
  output logic                         out_valid_o,
  output logic [exti_pkg::LINE_W-1:0]  pending_bits_o,
  output logic [exti_pkg::IRQ_W-1:0]   irq_requests_o
);
  import exti_pkg::*;

  logic [LINE_W-1:0] req;
  logic [IRQ_W-1:0]  irq_d;
  logic              valid_q;
  logic [LINE_W-1:0] pend_q;
  logic [IRQ_W-1:0]  irq_q;

  always_comb begin
    req   = pending_i & line_mask_i;
    irq_d = {|req[15:10], |req[9:5], req[4:0]};
  end

  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      pend_q <= pending_i;
      irq_q  <= irq_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign pending_bits_o = pend_q;
  assign irq_requests_o = irq_q;

endmodule

`default_nettype wire

// ===== design/external_interrupt_line_controller.sv =====
// Top level of the external interrupt line controller.
// The result is valid in the cycle after an input item is accepted.
// Throughput: one item per cycle; each line lane updates in the accept cycle.
// The single output register stalls input only while its result is not taken.
// Reset clears configuration, previous levels, pending bits and output valid.
`timescale 1ns / 1ps
`default_nettype none

module external_interrupt_line_controller #(
  parameter int unsigned NUM_LINES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [exti_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [exti_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      cmd_i,
  input  logic [exti_pkg::LINE_W-1:0]     pins_a_i,
  input  logic [exti_pkg::LINE_W-1:0]     pins_b_i,
  input  logic [exti_pkg::LINE_W-1:0]     pins_c_i,
  input  logic [exti_pkg::LINE_W-1:0]     pins_d_i,
  input  logic [exti_pkg::LINE_W-1:0]     pins_e_i,
  input  logic [exti_pkg::LINE_W-1:0]     clear_mask_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [exti_pkg::LINE_W-1:0]     pending_bits_o,
  output logic [exti_pkg::IRQ_W-1:0]      irq_requests_o
);
  import exti_pkg::*;

  logic [LINE_W-1:0]           line_mask_q;
  logic [LINE_W-1:0]           rise_en_q;
  logic [LINE_W-1:0]           fall_en_q;
  logic [LINE_W*PSEL_W-1:0]    port_sel_q;
  logic                        accept;
  lane_ctrl_t                  ctrl;
  logic [LINE_W-1:0]           pending_all;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mask_q <= '0;
      rise_en_q   <= '0;
      fall_en_q   <= '0;
      port_sel_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LINE_MASK:   line_mask_q <= cfg_data_i[LINE_W-1:0];
        REG_RISING_EN:   rise_en_q   <= cfg_data_i[LINE_W-1:0];
        REG_FALLING_EN:  fall_en_q   <= cfg_data_i[LINE_W-1:0];
        REG_PORT_SELECT: port_sel_q  <= cfg_data_i[LINE_W*PSEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    ctrl.sample = accept && (cmd_i == CMD_SAMPLE);
    ctrl.clear  = accept && (cmd_i == CMD_CLEAR);
  end

  for (genvar i = 0; i < LINE_W; i++) begin : g_line
    if (i < NUM_LINES) begin : g_lane
      exti_lane u_lane (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .pins_i      ({pins_e_i[i], pins_d_i[i], pins_c_i[i], pins_b_i[i], pins_a_i[i]}),
        .code_i      (port_sel_q[i*PSEL_W +: PSEL_W]),
        .rise_en_i   (rise_en_q[i]),
        .fall_en_i   (fall_en_q[i]),
        .clear_bit_i (clear_mask_i[i]),
        .pending_o   (pending_all[i])
      );
    end else begin : g_absent
      assign pending_all[i] = 1'b0;
    end
  end

  exti_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_valid_i),
    .pending_i      (pending_all),
    .line_mask_i    (line_mask_q),
    .out_ready_i    (out_ready_i),
    .ready_o        (in_ready_o),
    .out_valid_o    (out_valid_o),
    .pending_bits_o (pending_bits_o),
    .irq_requests_o (irq_requests_o)
  );

`ifndef ASSERT_OFF
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

  a_clear_drops_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> ((pending_bits_o & $past(clear_mask_i)) == '0))
    else $error("cleared pending bits still set");

  a_direct_irq_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((irq_requests_o[4:0] & ~pending_bits_o[4:0]) == 5'd0))
    else $error("request without pending bit");

  a_group_irq_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (irq_requests_o[5] || irq_requests_o[6])) |->
      ((!irq_requests_o[5] || (pending_bits_o[9:5] != 5'd0)) &&
       (!irq_requests_o[6] || (pending_bits_o[15:10] != 6'd0))))
    else $error("group request without pending line");

  a_absent_lines_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pending_bits_o >> NUM_LINES) == '0))
    else $error("pending bit set on absent line");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the external interrupt line controller.
`timescale 1ns / 1ps

module testbench;
  import exti_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned PHASE_ITEMS  = 78;
  localparam int unsigned HOLD_AFTER   = 150;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned SETTLE_WAIT  = 2;
  localparam int unsigned STALL_LIMIT  = 1000;

  localparam logic [1:0]           CMD_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_GAP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_GAP  = 3'd7;

  typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct packed {
    logic [1:0]             op;
    logic [4:0][LINE_W-1:0] pins;
    logic [LINE_W-1:0]      clr;
  } request_t;

  typedef struct packed {
    logic [LINE_W-1:0] pending;
    logic [IRQ_W-1:0]  irq;
  } status_t;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DAT_W-1:0]   data;
    request_t               req;
    bit                     typed;
    status_t                want;
  } step_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DAT_W-1:0]  cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic [1:0]            cmd_i        = '0;
  logic [LINE_W-1:0]     pins_a_i     = '0;
  logic [LINE_W-1:0]     pins_b_i     = '0;
  logic [LINE_W-1:0]     pins_c_i     = '0;
  logic [LINE_W-1:0]     pins_d_i     = '0;
  logic [LINE_W-1:0]     pins_e_i     = '0;
  logic [LINE_W-1:0]     clear_mask_i = '0;
  logic                  out_ready_i  = 1'b0;
  logic                  cfg_ready_o;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [LINE_W-1:0]     pending_bits_o;
  logic [IRQ_W-1:0]      irq_requests_o;

  external_interrupt_line_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .pins_a_i      (pins_a_i),
    .pins_b_i      (pins_b_i),
    .pins_c_i      (pins_c_i),
    .pins_d_i      (pins_d_i),
    .pins_e_i      (pins_e_i),
    .clear_mask_i  (clear_mask_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pending_bits_o(pending_bits_o),
    .irq_requests_o(irq_requests_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Controller image: registers, sampled levels and pending word
  logic [LINE_W-1:0]      ctl_mask;
  logic [LINE_W-1:0]      ctl_rise;
  logic [LINE_W-1:0]      ctl_fall;
  logic [CFG_DAT_W-1:0]   ctl_ports;
  logic [LINE_W-1:0]      seen_levels;
  logic [LINE_W-1:0]      latched;
  logic [4:0][LINE_W-1:0] recent_pins;

  status_t     status_due [$];
  step_t       plan [$];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned edges_latched;
  int unsigned reg_writes;
  int unsigned op_count [4];
  bit          calm;

  function automatic void store_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_LINE_MASK:   ctl_mask  = data[LINE_W-1:0];
      REG_RISING_EN:   ctl_rise  = data[LINE_W-1:0];
      REG_FALLING_EN:  ctl_fall  = data[LINE_W-1:0];
      REG_PORT_SELECT: ctl_ports = data;
      default: ;
    endcase
  endfunction

  function automatic status_t step_controller(request_t r);
    logic [LINE_W-1:0] lv;
    logic [LINE_W-1:0] rise;
    logic [LINE_W-1:0] fall;
    logic [LINE_W-1:0] req;
    logic [PSEL_W-1:0] code;
    status_t           s;
    if (r.op == CMD_SAMPLE) begin
      lv = '0;
      for (int i = 0; i < LINE_W; i++) begin
        code = ctl_ports[PSEL_W*i +: PSEL_W];
        if (code <= PORT_E) begin
          lv[i] = r.pins[code][i];
        end
      end
      rise = lv & ~seen_levels & ctl_rise;
      fall = ~lv & seen_levels & ctl_fall;
      edges_latched += $countones((rise | fall) & ~latched);
      latched |= rise | fall;
      seen_levels = lv;
    end else if (r.op == CMD_CLEAR) begin
      latched &= ~r.clr;
    end
    req = latched & ctl_mask;
    s.pending = latched;
    s.irq = {|req[15:10], |req[9:5], req[4:0]};
    return s;
  endfunction

  function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    step_t s;
    s = '{kind: ROW_CFG, idx: idx, data: data, req: '0, typed: 1'b0, want: '0};
    return s;
  endfunction

  function automatic step_t item_row(logic [1:0] op, logic [79:0] ports,
                                     logic [LINE_W-1:0] clr, bit typed = 1'b0,
                                     logic [LINE_W-1:0] pend = '0,
                                     logic [IRQ_W-1:0] irq = '0);
    step_t s;
    s.kind  = ROW_ITEM;
    s.idx   = '0;
    s.data  = '0;
    s.req   = '{op: op, pins: ports, clr: clr};
    s.typed = typed;
    s.want  = '{pending: pend, irq: irq};
    return s;
  endfunction

  function automatic logic [LINE_W-1:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return LINE_W'($urandom());
  endfunction

  function automatic logic [CFG_DAT_W-1:0] random_port_map();
    logic [CFG_DAT_W-1:0] m;
    int unsigned          pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    for (int i = 0; i < LINE_W; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        m[PSEL_W*i +: PSEL_W] = PSEL_W'($urandom_range(PORT_E + 1, 2**PSEL_W - 1));
      end else begin
        m[PSEL_W*i +: PSEL_W] = PSEL_W'($urandom_range(0, PORT_E));
      end
    end
    return m;
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned port;
    int unsigned line;
    pick = $urandom_range(0, 19);
    if (pick < 11) r.op = CMD_SAMPLE;
    else if (pick < 14) r.op = CMD_READ;
    else if (pick < 19) r.op = CMD_CLEAR;
    else r.op = CMD_UNUSED;
    if ($urandom_range(0, 1) == 1) begin
      port = $urandom_range(0, 4);
      line = $urandom_range(0, LINE_W - 1);
      r.pins = recent_pins;
      r.pins[port][line] = ~r.pins[port][line];
    end else begin
      for (int p = 0; p < 5; p++) r.pins[p] = random_word();
    end
    recent_pins = r.pins;
    pick = $urandom_range(0, 3);
    if (pick == 0) r.clr = LINE_W'(1) << $urandom_range(0, LINE_W - 1);
    else r.clr = random_word();
    return r;
  endfunction

  // Drop both valids, wait for every result, then let the pipeline empty
  task automatic settle();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    store_register(idx, data);
    reg_writes++;
  endtask

  task automatic send_item(request_t r, bit may_idle, bit typed = 1'b0, status_t want = '0);
    status_t     got;
    int unsigned gap;
    gap = (may_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    cfg_valid_i <= 1'b0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= r.op;
    pins_a_i     <= r.pins[0];
    pins_b_i     <= r.pins[1];
    pins_c_i     <= r.pins[2];
    pins_d_i     <= r.pins[3];
    pins_e_i     <= r.pins[4];
    clear_mask_i <= r.clr;
    do @(posedge clk_i); while (!in_ready_o);
    got = step_controller(r);
    status_due.push_back(typed ? want : got);
    op_count[r.op]++;
    items_sent++;
  endtask

  task automatic hold_ready(bit level, int unsigned cycles);
    repeat (cycles) begin
      @(posedge clk_i);
      out_ready_i <= level;
    end
  endtask

  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (status_due.size() == 0) begin
        $error("unexpected result: pending_bits %h irq_requests %h",
               pending_bits_o, irq_requests_o);
        mismatches++;
      end else begin
        want = status_due.pop_front();
        if (want.pending !== pending_bits_o) begin
          $error("pending_bits: expected %h, got %h", want.pending, pending_bits_o);
          mismatches++;
        end
        if (want.irq !== irq_requests_o) begin
          $error("irq_requests: expected %h, got %h", want.irq, irq_requests_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : result_sink
    bit held;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        hold_ready(1'b0, HOLD_CYCLES);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        hold_ready(1'b0, $urandom_range(1, 9));
      end else begin
        hold_ready(1'b1, $urandom_range(1, 24));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("FAIL external_interrupt_line_controller");
    $finish;
  end

  initial begin : stimulus
    bit busy;
    ctl_mask      = '0;
    ctl_rise      = '0;
    ctl_fall      = '0;
    ctl_ports     = '0;
    seen_levels   = '0;
    latched       = '0;
    recent_pins   = '0;
    items_sent    = 0;
    results_seen  = 0;
    mismatches    = 0;
    edges_latched = 0;
    reg_writes    = 0;
    op_count      = '{default: 0};
    calm          = 1'b0;

    plan = '{
      item_row(CMD_SAMPLE, 80'h0000_0000_0000_0000_FFFF, 16'h0000, 1, 16'h0000, 7'h00),
      item_row(CMD_READ,   80'h0000_0000_0000_0000_0000, 16'hFFFF, 1, 16'h0000, 7'h00),
      cfg_row(REG_LINE_MASK, 64'hFFFF_FFFF_FFFF_FFFF),
      cfg_row(REG_RISING_EN, 64'h0000_0000_0000_FFFF),
      item_row(CMD_SAMPLE, 80'h0000_0000_0000_0000_0000, 16'h0000, 1, 16'h0000, 7'h00),
      item_row(CMD_SAMPLE, 80'h0000_0000_0000_0000_FFFF, 16'h0000, 1, 16'hFFFF, 7'h7F),
      item_row(CMD_CLEAR,  80'h0000_0000_0000_0000_0000, 16'hFFFF, 1, 16'h0000, 7'h00),
      // unused code leaves the sampled levels alone
      item_row(CMD_UNUSED, 80'h0000_0000_0000_0000_0000, 16'hFFFF, 1, 16'h0000, 7'h00),
      cfg_row(REG_FALLING_EN, 64'hA5A5_0000_0000_FFFF),
      item_row(CMD_SAMPLE, 80'h0000_0000_0000_0000_0000, 16'h0000, 1, 16'hFFFF, 7'h7F),
      item_row(CMD_CLEAR,  80'h0000_0000_0000_0000_0000, 16'h0001, 1, 16'hFFFE, 7'h7E),
      item_row(CMD_CLEAR,  80'h0000_0000_0000_0000_0000, 16'h03E0, 1, 16'hFC1E, 7'h5E),
      item_row(CMD_CLEAR,  80'h0000_0000_0000_0000_0000, 16'hFC00, 1, 16'h001E, 7'h1E),
      cfg_row(REG_LINE_MASK, 64'h0000_0000_0000_0000),
      item_row(CMD_READ,   80'hFFFF_FFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1, 16'h001E, 7'h00),
      // codes above the last port read low
      cfg_row(REG_PORT_SELECT, 64'hFFFF_FFFF_FFFF_FFFF),
      item_row(CMD_SAMPLE, 80'hFFFF_FFFF_FFFF_FFFF_FFFF, 16'h0000, 1, 16'h001E, 7'h00),
      cfg_row(REG_PORT_SELECT, 64'h4444_4444_4444_4444),
      item_row(CMD_SAMPLE, 80'hFFFF_0000_0000_0000_0000, 16'h0000, 1, 16'hFFFF, 7'h00),
      cfg_row(REG_LINE_MASK, 64'h0000_0000_0000_8421),
      item_row(CMD_CLEAR,  80'h0000_0000_0000_0000_0000, 16'hFFFF, 1, 16'h0000, 7'h00),
      // new port code compares against the old pin level
      cfg_row(REG_PORT_SELECT, 64'h3333_3333_3333_3333),
      item_row(CMD_SAMPLE, 80'hFFFF_00FF_0000_0000_0000, 16'h0000, 1, 16'hFF00, 7'h40),
      cfg_row(REG_FIRST_GAP, 64'hFFFF_FFFF_FFFF_FFFF),
      cfg_row(REG_LAST_GAP, 64'h0000_0000_0000_0000),
      item_row(CMD_READ,   80'h0000_0000_0000_0000_0000, 16'h0000, 1, 16'hFF00, 7'h40),
      cfg_row(REG_PORT_SELECT, 64'h0123_4567_89AB_CDEF),
      item_row(CMD_SAMPLE, 80'hFF00_0F0F_F0F0_5555_AAAA, 16'h0000),
      cfg_row(REG_PORT_SELECT, 64'h4321_0432_1043_2104),
      item_row(CMD_SAMPLE, 80'h00FF_F0F0_0F0F_AAAA_5555, 16'h0000),
      item_row(CMD_SAMPLE, 80'h0000_0000_0000_0000_0000, 16'h0000),
      cfg_row(REG_LINE_MASK, 64'h0000_0000_0000_FFFF),
      item_row(CMD_READ,   80'h0000_0000_0000_0000_0000, 16'h0000)
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        write_reg(plan[k].idx, plan[k].data);
      end else begin
        send_item(plan[k].req, 1'b1, plan[k].typed, plan[k].want);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        write_reg(REG_LINE_MASK, {$urandom(), 16'($urandom()), random_word()});
      end
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        write_reg(REG_RISING_EN, {$urandom(), 16'($urandom()), random_word()});
      end
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        write_reg(REG_FALLING_EN, {$urandom(), 16'($urandom()), random_word()});
      end
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        write_reg(REG_PORT_SELECT, random_port_map());
      end
      if ($urandom_range(0, 4) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_GAP, REG_LAST_GAP)),
                  {$urandom(), $urandom()});
      end
      calm = (phase == NUM_PHASES - 1);
      busy = (phase % 3 == 1);
      repeat (PHASE_ITEMS) send_item(random_request(), !calm && !busy);
    end

    settle();
    $display("Covered %0d items (%0d samples, %0d reads, %0d clears, %0d unused code)",
             items_sent, op_count[CMD_SAMPLE], op_count[CMD_READ], op_count[CMD_CLEAR],
             op_count[CMD_UNUSED]);
    $display("with %0d register writes; %0d edges latched, %0d results compared.",
             reg_writes, edges_latched, results_seen);
    if (mismatches == 0) begin
      $display("PASS external_interrupt_line_controller");
    end else begin
      $display("FAIL external_interrupt_line_controller");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/exti_pkg.sv
design/exti_lane.sv
design/exti_merge.sv
design/external_interrupt_line_controller.sv
sim/testbench.sv
